### rtl/brfd_pkg.sv
`timescale 1ns / 1ps

package brfd_pkg;

    // block limit and the bitmap length it allows
    localparam int MAX_BLOCKS     = 65536;
    localparam int MASK_BYTES_MAX = (MAX_BLOCKS + 7) / 8;

    localparam int POS_W   = 17;
    localparam int MCNT_W  = 14;
    localparam int START_W = 16;
    localparam int LEN_W   = 17;

    localparam logic [POS_W:0]    LIMIT      = (POS_W + 1)'(MAX_BLOCKS);
    localparam logic [MCNT_W-1:0] MASK_LIMIT = MCNT_W'(MASK_BYTES_MAX);
    localparam logic [7:0]        CONT_BYTE  = 8'hff;

    // ranges one input byte can give, and the count that holds them
    localparam int MAX_RANGES = 5;
    localparam int CNT_W      = 3;

    // request queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_OVERFLOW  = 3'd1,
        ERR_ZERO_FILL = 3'd2,
        ERR_SKIP_PAST = 3'd3,
        ERR_FILL_PAST = 3'd4,
        ERR_TRUNCATED = 3'd5,
        ERR_MASK_LONG = 3'd6
    } err_t;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
    } range_t;

    // everything one input byte produces
    typedef struct packed {
        range_t [MAX_RANGES-1:0] ranges;
        logic [CNT_W-1:0]        count;
        err_t                    err;
        logic                    last;
    } rec_t;

endpackage

### rtl/brfd_front.sv
`timescale 1ns / 1ps

module brfd_front
    import brfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic       s_tuser,   // format
    input  logic       s_tlast,   // last_byte
    input  logic       q_full,
    output logic       q_push,
    output rec_t       q_rec
);

    logic              reading_fill_reg, reading_fill_next;
    logic [POS_W-1:0]  length_sum_reg,   length_sum_next;
    logic [POS_W-1:0]  block_pos_reg,    block_pos_next;
    logic [POS_W-1:0]  pending_skip_reg, pending_skip_next;
    logic              run_open_reg,     run_open_next;
    logic [POS_W-1:0]  run_begin_reg,    run_begin_next;
    logic [MCNT_W-1:0] mask_cnt_reg,     mask_cnt_next;
    err_t              err_reg,          err_next;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    // decode one byte against the current state
    always_comb begin
        logic [POS_W:0]   sum_v;
        logic [POS_W:0]   pos_v;
        logic [POS_W:0]   end_v;
        logic [POS_W-1:0] base_v;
        logic [POS_W-1:0] idx_v;
        logic [CNT_W-1:0] cnt_v;

        reading_fill_next = reading_fill_reg;
        length_sum_next   = length_sum_reg;
        block_pos_next    = block_pos_reg;
        pending_skip_next = pending_skip_reg;
        run_open_next     = run_open_reg;
        run_begin_next    = run_begin_reg;
        mask_cnt_next     = mask_cnt_reg;
        err_next          = err_reg;
        q_rec             = '0;
        cnt_v             = '0;

        sum_v  = {1'b0, length_sum_reg} + (POS_W + 1)'(s_tdata);
        pos_v  = {1'b0, block_pos_reg} + {1'b0, pending_skip_reg};
        end_v  = pos_v + sum_v;
        base_v = {mask_cnt_reg, 3'b000};
        idx_v  = base_v;

        if (err_reg == ERR_NONE) begin
            if (!s_tuser) begin
                // run-length: accumulate, then close a skip or a fill
                length_sum_next = sum_v[POS_W-1:0];
                if (sum_v > LIMIT) begin
                    err_next = ERR_OVERFLOW;
                end else if (s_tdata != CONT_BYTE) begin
                    length_sum_next   = '0;
                    reading_fill_next = !reading_fill_reg;
                    if (!reading_fill_reg) begin
                        pending_skip_next = sum_v[POS_W-1:0];
                    end else if (sum_v == '0) begin
                        err_next = ERR_ZERO_FILL;
                    end else if (pos_v > LIMIT) begin
                        err_next = ERR_SKIP_PAST;
                    end else begin
                        block_pos_next    = pos_v[POS_W-1:0];
                        pending_skip_next = '0;
                        if (end_v > LIMIT) begin
                            err_next = ERR_FILL_PAST;
                        end else begin
                            q_rec.ranges[0].start = pos_v[START_W-1:0];
                            q_rec.ranges[0].len   = sum_v[LEN_W-1:0];
                            cnt_v                 = CNT_W'(1);
                            block_pos_next        = end_v[POS_W-1:0];
                        end
                    end
                end
            end else begin
                // bitmap: walk the eight bits, LSB first
                if (mask_cnt_reg >= MASK_LIMIT) begin
                    err_next = ERR_MASK_LONG;
                end else begin
                    for (int i = 0; i < 8; i++) begin
                        idx_v = base_v + POS_W'(i);
                        if (s_tdata[i]) begin
                            if (!run_open_next) begin
                                run_open_next  = 1'b1;
                                run_begin_next = idx_v;
                            end
                        end else if (run_open_next) begin
                            if (cnt_v < CNT_W'(MAX_RANGES)) begin
                                q_rec.ranges[cnt_v].start = run_begin_next[START_W-1:0];
                                q_rec.ranges[cnt_v].len   = LEN_W'(idx_v - run_begin_next);
                                cnt_v = cnt_v + CNT_W'(1);
                            end
                            run_open_next = 1'b0;
                        end
                    end
                    mask_cnt_next = mask_cnt_reg + MCNT_W'(1);
                end
            end
        end

        // end of message: truncation check or close the open run
        if (s_tlast && err_next == ERR_NONE) begin
            if (!s_tuser) begin
                if (s_tdata == CONT_BYTE || reading_fill_next) begin
                    err_next = ERR_TRUNCATED;
                end
            end else if (run_open_next) begin
                if (cnt_v < CNT_W'(MAX_RANGES)) begin
                    q_rec.ranges[cnt_v].start = run_begin_next[START_W-1:0];
                    q_rec.ranges[cnt_v].len   =
                        LEN_W'({mask_cnt_next, 3'b000} - run_begin_next);
                    cnt_v = cnt_v + CNT_W'(1);
                end
                run_open_next = 1'b0;
            end
        end

        q_rec.count = cnt_v;
        q_rec.err   = err_next;
        q_rec.last  = s_tlast;
    end

    // advance state on each accepted request; drop it all after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reading_fill_reg <= 1'b0;
            length_sum_reg   <= '0;
            block_pos_reg    <= '0;
            pending_skip_reg <= '0;
            run_open_reg     <= 1'b0;
            run_begin_reg    <= '0;
            mask_cnt_reg     <= '0;
            err_reg          <= ERR_NONE;
        end else if (q_push) begin
            if (s_tlast) begin
                reading_fill_reg <= 1'b0;
                length_sum_reg   <= '0;
                block_pos_reg    <= '0;
                pending_skip_reg <= '0;
                run_open_reg     <= 1'b0;
                run_begin_reg    <= '0;
                mask_cnt_reg     <= '0;
                err_reg          <= ERR_NONE;
            end else begin
                reading_fill_reg <= reading_fill_next;
                length_sum_reg   <= length_sum_next;
                block_pos_reg    <= block_pos_next;
                pending_skip_reg <= pending_skip_next;
                run_open_reg     <= run_open_next;
                run_begin_reg    <= run_begin_next;
                mask_cnt_reg     <= mask_cnt_next;
                err_reg          <= err_next;
            end
        end
    end

endmodule

### rtl/brfd_queue.sv
`timescale 1ns / 1ps

module brfd_queue
    import brfd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  rec_t push_rec,
    output logic full,
    input  logic pop,
    output rec_t head_rec,
    output logic empty
);

    rec_t            mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   count_reg,  count_next;
    logic            do_push, do_pop;

    assign full     = count_reg == (Q_AW + 1)'(Q_DEPTH);
    assign empty    = count_reg == '0;
    assign head_rec = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // move pointers and fill level
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (Q_AW + 1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (Q_AW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // hold entries; no reset on payload
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

### rtl/brfd_back.sv
`timescale 1ns / 1ps

module brfd_back
    import brfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  rec_t        head_rec,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // range_start, range_length, last_for_item, error_code
    output logic        m_tuser,  // range_valid
    output logic        m_tlast   // end_of_message
);

    rec_t             cur_reg,   cur_next;
    logic             cur_v_reg, cur_v_next;
    logic [CNT_W-1:0] idx_reg,   idx_next;
    logic [CNT_W-1:0] num_res;
    logic             final_res;
    logic             taken;
    logic             advance;
    range_t           sel;

    assign num_res   = (cur_reg.count == '0) ? CNT_W'(1) : cur_reg.count;
    assign final_res = idx_reg == num_res - CNT_W'(1);
    assign taken     = m_tvalid && m_tready;
    assign advance   = !cur_v_reg || (taken && final_res);
    assign q_pop     = advance && !q_empty;

    // load the next request once the current one is drained
    always_comb begin
        cur_next   = cur_reg;
        cur_v_next = cur_v_reg;
        idx_next   = idx_reg;
        if (advance) begin
            cur_v_next = !q_empty;
            cur_next   = head_rec;
            idx_next   = '0;
        end else if (taken) begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_v_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            cur_v_reg <= cur_v_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    // pick the current result
    always_comb begin
        sel = '0;
        if (cur_reg.count != '0) begin
            sel = cur_reg.ranges[idx_reg];
        end
    end

    assign m_tvalid = cur_v_reg;
    assign m_tuser  = cur_reg.count != '0;
    assign m_tlast  = cur_reg.last && final_res;
    assign m_tdata  = {3'b000, cur_reg.err, final_res, sel.len, sel.start};

endmodule

### rtl/block_range_field_decoder.sv
`timescale 1ns / 1ps

// Channel  Dir  Ports               tdata / tuser / tlast
// s_       in   s_tvalid,s_tready   data_byte / format / last_byte
// m_       out  m_tvalid,m_tready   start,length,last_for_item,error / range_valid / eom
//
// One byte is accepted per cycle while the four-entry request queue has room.
// Each byte gives one to five results, sent one per cycle from the back end while
// m_tready is high; a dense bitmap byte gives up to five results there, so the
// queue fills and s_tready drops when output runs slower than input.
// Synchronous active-low reset empties the queue and clears decode state.

module block_range_field_decoder
    import brfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // data_byte
    input  logic        s_tuser,  // format
    input  logic        s_tlast,  // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // range_start[15:0], range_length[32:16],
                                  // last_for_item[33], error_code[36:34]
    output logic        m_tuser,  // range_valid
    output logic        m_tlast   // end_of_message
);

    logic q_push, q_full, q_pop, q_empty;
    rec_t push_rec, head_rec;

    brfd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_rec    (push_rec)
    );

    brfd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (q_pop),
        .head_rec (head_rec),
        .empty    (q_empty)
    );

    brfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_rec (head_rec),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef ASSERT_OFF
    // a result without a range carries zero start and length
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[32:0] == 33'd0)
        else $error("empty result carries range data");

    // a range is never empty and never carries an error
    a_range_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[32:16] != 17'd0 && m_tdata[36:34] == ERR_NONE)
        else $error("range with zero length or error");

    // end of message is always the final result of its byte
    a_eom_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[33])
        else $error("end of message before final result");
`endif

endmodule
